@@ rtl/ilsfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsfe_pkg
// Shared types and constants of the inductor line sensor front end.
// ----------------------------------------------------------------------------
package ilsfe_pkg;

  localparam int NormBits = 7;
  localparam int DevBits  = 10;
  localparam int NumLanes = 4;

  localparam logic [7:0] RegAdcFloor      = 8'd0;
  localparam logic [7:0] RegAdcCeiling    = 8'd1;
  localparam logic [7:0] RegModeSelect    = 8'd2;
  localparam logic [7:0] RegStopThreshold = 8'd3;

  typedef struct packed {
    logic [7:0] floor_v;
    logic [7:0] ceil_v;
    logic [1:0] mode;
    logic [8:0] stop_thr;
  } cfg_t;

  // Outer and inner coefficients in tenths, turn limit per mode.
  function automatic logic [3:0] coef_outer(input logic [1:0] m);
    case (m)
      2'd0:    coef_outer = 4'd12;
      2'd1:    coef_outer = 4'd14;
      default: coef_outer = 4'd15;
    endcase
  endfunction

  function automatic logic [3:0] coef_inner(input logic [1:0] m);
    case (m)
      2'd0:    coef_inner = 4'd10;
      2'd1:    coef_inner = 4'd12;
      default: coef_inner = 4'd13;
    endcase
  endfunction

  function automatic logic [5:0] turn_limit(input logic [1:0] m);
    case (m)
      2'd0:    turn_limit = 6'd30;
      2'd1:    turn_limit = 6'd40;
      default: turn_limit = 6'd50;
    endcase
  endfunction

endpackage

@@ rtl/ilsfe_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsfe_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ilsfe_divider #(
  parameter int NUM_BITS = 16,
  parameter int DEN_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);
  localparam int CntBits = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] shreg;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] dreg;
  logic [CntBits-1:0]  cnt;
  logic                busy;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;

  assign trial = {rem[DEN_BITS-1:0], shreg[NUM_BITS-1]};
  assign diff  = trial - {1'b0, dreg};
  assign quot  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      dreg  <= den;
      rem   <= '0;
    end else if (busy) begin
      if (!diff[DEN_BITS]) begin
        rem   <= diff;
        shreg <= {shreg[NUM_BITS-2:0], 1'b1};
      end else begin
        rem   <= trial;
        shreg <= {shreg[NUM_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/ilsfe_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsfe_lane
// One channel: median of three, clamp, and normalize to 0..100.
// ----------------------------------------------------------------------------
module ilsfe_lane #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SAMPLE_BITS-1:0]    sa,
  input  logic [SAMPLE_BITS-1:0]    sb,
  input  logic [SAMPLE_BITS-1:0]    sc,
  input  ilsfe_pkg::cfg_t           cfg,
  output logic                      done,
  output logic [ilsfe_pkg::NormBits-1:0] level
);
  import ilsfe_pkg::*;

  localparam int NB = 16;

  logic [SAMPLE_BITS-1:0] lo, hi, med, v;
  logic [7:0] clamped;
  logic       zero_case;
  logic       zero_q;
  logic [NB-1:0] q;
  logic       div_done;

  always_comb begin
    lo  = sa;
    hi  = sb;
    if (sa > sb) begin
      lo = sb;
      hi = sa;
    end
    med = hi;
    if (hi > sc) med = sc;
    if (lo > med) med = lo;
    v = med;
    // the clamped value never exceeds the 8-bit ceiling
    clamped = (v > SAMPLE_BITS'(cfg.ceil_v)) ? cfg.ceil_v : 8'(v);
    zero_case = (clamped <= cfg.floor_v);
  end

  always_ff @(posedge clk) begin
    if (start) zero_q <= zero_case;
  end

  ilsfe_divider #(.NUM_BITS(NB), .DEN_BITS(8)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (NB'(7'd100 * 8'(clamped - cfg.floor_v))),
    .den   (cfg.ceil_v - cfg.floor_v),
    .done  (div_done),
    .quot  (q)
  );

  assign done  = div_done;
  assign level = zero_q ? '0 : NormBits'(q);

endmodule

@@ rtl/ilsfe_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsfe_merge
// Combines lane levels: stop latch and signed deviation by serial division.
// ----------------------------------------------------------------------------
module ilsfe_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [6:0]            l,
  input  logic [6:0]            lm,
  input  logic [6:0]            rm,
  input  logic [6:0]            r,
  input  ilsfe_pkg::cfg_t       cfg,
  output logic                  done,
  output logic signed [9:0]     dev,
  output logic                  stopped,
  output logic                  turning,
  output logic                  dzero
);
  import ilsfe_pkg::*;

  // numerator magnitude reaches 280000
  localparam int NB = 20;

  logic [1:0]         m;
  logic [8:0]         sum;
  logic signed [8:0]  d_out, d_in;
  logic signed [13:0] wsum;
  logic signed [20:0] num;
  logic [11:0]        den;
  logic               neg_q, dz_q;
  logic [1:0]         m_q;
  logic [NB-1:0]      q;
  logic               div_done;
  logic [9:0]         mag;

  always_comb begin
    m     = (cfg.mode == 2'd3) ? 2'd2 : cfg.mode;
    sum   = 9'(l) + 9'(lm) + 9'(rm) + 9'(r);
    d_out = $signed({2'b0, l}) - $signed({2'b0, r});
    d_in  = $signed({2'b0, lm}) - $signed({2'b0, rm});
    wsum  = d_out * $signed({1'b0, coef_outer(m)}) + d_in * $signed({1'b0, coef_inner(m)});
    num   = wsum * 21'sd100;
    den   = 12'(10 * (l + r + 0)) + 12'(5 * (lm + rm + 0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (start && (sum < cfg.stop_thr)) begin
      stopped <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_q <= num[20];
      dz_q  <= (den == '0);
      m_q   <= m;
    end
  end

  ilsfe_divider #(.NUM_BITS(NB), .DEN_BITS(12)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (NB'(num[20] ? -num : num)),
    .den   (den),
    .done  (div_done),
    .quot  (q)
  );

  always_comb begin
    mag = (q > NB'(300)) ? 10'd300 : 10'(q);
    if (dz_q) mag = '0;
  end

  assign done    = div_done;
  assign dev     = neg_q ? -$signed(mag) : $signed(mag);
  assign dzero   = dz_q;
  assign turning = !dz_q && (mag >= 10'(turn_limit(m_q)));

endmodule

@@ rtl/inductor_line_sensor_front_end.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inductor_line_sensor_front_end
// Four lanes normalize each channel, then a merge stage forms the deviation.
// ----------------------------------------------------------------------------
// Flow: each item passes the lane division, then the deviation division,
// then the handoff into the result registers.
// A new item is accepted only while idle with no result waiting, so the pace
// is set by the two serial dividers, the result handoff and any output stall.
// Reset: synchronous; clears the stop latch, handshake state and registers
// to floor 0, ceiling 100, mode 0, stop threshold 20.
module inductor_line_sensor_front_end #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic psel, penable, pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic in_valid,
  output logic in_stall,
  input  logic [SAMPLE_BITS-1:0] left_sample_a, left_sample_b, left_sample_c,
  input  logic [SAMPLE_BITS-1:0] leftmid_sample_a, leftmid_sample_b, leftmid_sample_c,
  input  logic [SAMPLE_BITS-1:0] rightmid_sample_a, rightmid_sample_b, rightmid_sample_c,
  input  logic [SAMPLE_BITS-1:0] right_sample_a, right_sample_b, right_sample_c,
  output logic out_valid,
  input  logic out_stall,
  output logic [6:0] norm_left, norm_leftmid, norm_rightmid, norm_right,
  output logic signed [9:0] deviation,
  output logic stopped, turning, divisor_zero
);
  import ilsfe_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLane = 2'd1;
  localparam logic [1:0] StMrg  = 2'd2;

  cfg_t       cfg;
  logic [1:0] state;
  logic       in_acc, lane_done, mrg_start, mrg_done;
  logic [3:0] ldone;
  logic [6:0] lv [NumLanes];
  logic [6:0] lq [NumLanes];
  logic signed [9:0] m_dev;
  logic m_stop, m_turn, m_dz;
  logic [7:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = {6'd0, paddr[3:2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_v  <= 8'd0;
      cfg.ceil_v   <= 8'd100;
      cfg.mode     <= 2'd0;
      cfg.stop_thr <= 9'd20;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegAdcFloor:      cfg.floor_v  <= pwdata[7:0];
        RegAdcCeiling:    cfg.ceil_v   <= pwdata[7:0];
        RegModeSelect:    cfg.mode     <= pwdata[1:0];
        RegStopThreshold: cfg.stop_thr <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegAdcFloor:      prdata = {24'd0, cfg.floor_v};
      RegAdcCeiling:    prdata = {24'd0, cfg.ceil_v};
      RegModeSelect:    prdata = {30'd0, cfg.mode};
      RegStopThreshold: prdata = {23'd0, cfg.stop_thr};
      default:          prdata = '0;
    endcase
  end

  assign in_stall  = (state != StIdle) || out_valid;
  assign in_acc    = in_valid && !in_stall;
  assign lane_done = ldone[0];
  assign mrg_start = (state == StLane) && lane_done;

  ilsfe_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_l0 (.clk(clk), .rst(rst), .start(in_acc),
    .sa(left_sample_a), .sb(left_sample_b), .sc(left_sample_c), .cfg(cfg),
    .done(ldone[0]), .level(lv[0]));
  ilsfe_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_l1 (.clk(clk), .rst(rst), .start(in_acc),
    .sa(leftmid_sample_a), .sb(leftmid_sample_b), .sc(leftmid_sample_c), .cfg(cfg),
    .done(ldone[1]), .level(lv[1]));
  ilsfe_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_l2 (.clk(clk), .rst(rst), .start(in_acc),
    .sa(rightmid_sample_a), .sb(rightmid_sample_b), .sc(rightmid_sample_c), .cfg(cfg),
    .done(ldone[2]), .level(lv[2]));
  ilsfe_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_l3 (.clk(clk), .rst(rst), .start(in_acc),
    .sa(right_sample_a), .sb(right_sample_b), .sc(right_sample_c), .cfg(cfg),
    .done(ldone[3]), .level(lv[3]));

  always_ff @(posedge clk) begin
    if (mrg_start) begin
      for (int i = 0; i < NumLanes; i++) lq[i] <= lv[i];
    end
  end

  ilsfe_merge u_mrg (.clk(clk), .rst(rst), .start(mrg_start),
    .l(lv[0]), .lm(lv[1]), .rm(lv[2]), .r(lv[3]), .cfg(cfg),
    .done(mrg_done), .dev(m_dev), .stopped(m_stop), .turning(m_turn), .dzero(m_dz));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        StIdle: if (in_acc) state <= StLane;
        StLane: if (lane_done) state <= StMrg;
        StMrg: begin
          if (mrg_done) begin
            state     <= StIdle;
            out_valid <= 1'b1;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Hold the result registers until the item is taken.
  always_ff @(posedge clk) begin
    if (state == StMrg && mrg_done) begin
      norm_left     <= lq[0];
      norm_leftmid  <= lq[1];
      norm_rightmid <= lq[2];
      norm_right    <= lq[3];
      deviation     <= m_dev;
      stopped       <= m_stop;
      turning       <= m_turn;
      divisor_zero  <= m_dz;
    end
  end

  a_lanes_sync: assert property (@(posedge clk) disable iff (rst)
    ldone[0] |-> (ldone[1] && ldone[2] && ldone[3])) else $error("lane skew");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !in_acc) else $error("accept while busy");
  a_dz_no_turn: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(divisor_zero && turning)) else $error("turn on zero divisor");

endmodule

@@ sim/inductor_line_sensor_front_end_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inductor_line_sensor_front_end_tb
// Drives sample frames and register writes into the sensor front end and
// checks every normalized level, deviation and flag against a local predictor.
// ----------------------------------------------------------------------------
module inductor_line_sensor_front_end_tb;
  import ilsfe_pkg::*;

  typedef struct {
    logic [7:0] s [12];
  } frame_t;

  typedef struct {
    logic [6:0] lvl [4];
    logic signed [9:0] dev;
    logic stp, trn, dz;
  } steer_t;

  class steer_board;
    logic [7:0] flr, ceil;
    logic [1:0] mode;
    logic [8:0] thr;
    bit latch;
    steer_t pending [$];
    int errors;

    function void clear();
      flr = 8'd0; ceil = 8'd100; mode = 2'd0; thr = 9'd20; latch = 0;
      pending.delete(); errors = 0;
    endfunction

    function int unsigned level(int unsigned a, int unsigned b, int unsigned c);
      int unsigned lo, hi, v;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      v = (c < lo) ? lo : ((c > hi) ? hi : c);
      if (v > ceil) v = ceil;
      if (v <= flr) return 0;
      return (100 * (v - flr)) / (ceil - flr);
    endfunction

    function void note_frame(frame_t f);
      steer_t e;
      int unsigned sum;
      int m, outer, inner, lim;
      longint num, den, q;
      sum = 0;
      for (int ch = 0; ch < 4; ch++) begin
        e.lvl[ch] = 7'(level(f.s[3*ch], f.s[3*ch+1], f.s[3*ch+2]));
        sum += e.lvl[ch];
      end
      if (sum < thr) latch = 1;
      m = (mode > 2) ? 2 : mode;
      outer = (m == 0) ? 12 : (m == 1) ? 14 : 15;
      inner = (m == 0) ? 10 : (m == 1) ? 12 : 13;
      lim   = (m == 0) ? 30 : (m == 1) ? 40 : 50;
      num = 100 * (outer * (longint'(e.lvl[0]) - e.lvl[3])
                 + inner * (longint'(e.lvl[1]) - e.lvl[2]));
      den = 10 * (longint'(e.lvl[0]) + e.lvl[3]) + 5 * (longint'(e.lvl[1]) + e.lvl[2]);
      e.dz = (den == 0);
      e.trn = 0;
      q = 0;
      if (den != 0) begin
        q = num / den;
        if (q > 300) q = 300;
        if (q < -300) q = -300;
        e.trn = (q >= lim) || (q <= -lim);
      end
      e.dev = q[9:0];
      e.stp = latch;
      pending.push_back(e);
    endfunction

    function void check(steer_t got);
      steer_t e;
      if (pending.size() == 0) begin
        $display("result with no item pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int ch = 0; ch < 4; ch++)
        if (got.lvl[ch] !== e.lvl[ch]) begin
          $display("level %0d: got %0d exp %0d", ch, got.lvl[ch], e.lvl[ch]);
          errors++;
        end
      if (got.dev !== e.dev) begin
        $display("deviation: got %0d exp %0d", got.dev, e.dev); errors++;
      end
      if (got.stp !== e.stp) begin
        $display("stopped: got %b exp %b", got.stp, e.stp); errors++;
      end
      if (got.trn !== e.trn) begin
        $display("turning: got %b exp %b", got.trn, e.trn); errors++;
      end
      if (got.dz !== e.dz) begin
        $display("divisor_zero: got %b exp %b", got.dz, e.dz); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [7:0] smp [12];
  logic [6:0] norm_left, norm_leftmid, norm_rightmid, norm_right;
  logic signed [9:0] deviation;
  logic stopped, turning, divisor_zero;

  steer_board board = new();
  int idle_cycles;
  int stall_mode;

  initial for (int i = 0; i < 12; i++) smp[i] = '0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  inductor_line_sensor_front_end DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall,
    .left_sample_a(smp[0]), .left_sample_b(smp[1]), .left_sample_c(smp[2]),
    .leftmid_sample_a(smp[3]), .leftmid_sample_b(smp[4]), .leftmid_sample_c(smp[5]),
    .rightmid_sample_a(smp[6]), .rightmid_sample_b(smp[7]),
    .rightmid_sample_c(smp[8]),
    .right_sample_a(smp[9]), .right_sample_b(smp[10]), .right_sample_c(smp[11]),
    .out_valid, .out_stall, .norm_left, .norm_leftmid, .norm_rightmid, .norm_right,
    .deviation, .stopped, .turning, .divisor_zero
  );

  // result side: check on accept, stall on a pattern that changes over time
  always @(posedge clk) begin
    steer_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.lvl[0] = norm_left; got.lvl[1] = norm_leftmid;
        got.lvl[2] = norm_rightmid; got.lvl[3] = norm_right;
        got.dev = deviation; got.stp = stopped; got.trn = turning;
        got.dz = divisor_zero;
        board.check(got);
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // watchdog: count cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx[1:0], 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegAdcFloor:      board.flr = val[7:0];
      RegAdcCeiling:    board.ceil = val[7:0];
      RegModeSelect:    board.mode = val[1:0];
      RegStopThreshold: board.thr = val[8:0];
      default: ;
    endcase
    // let the bus go idle before the next access
    @(posedge clk);
  endtask

  // hold the frame until the block takes it
  task automatic send_frame(input frame_t f);
    for (int i = 0; i < 12; i++) smp[i] <= f.s[i];
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_frame(f);
  endtask

  task automatic pause_input();
    in_valid <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic frame_t rand_frame(int kind);
    frame_t f;
    logic [7:0] base;
    for (int ch = 0; ch < 4; ch++) begin
      base = 8'($urandom_range(0, 255));
      for (int k = 0; k < 3; k++)
        case (kind)
          0: f.s[3*ch+k] = 8'($urandom_range(0, 255));
          1: f.s[3*ch+k] = 8'((base > 245 ? 245 : base) + $urandom_range(0, 10));
          default: f.s[3*ch+k] = $urandom_range(0, 3) == 0 ? 8'd0 : base;
        endcase
    end
    return f;
  endfunction

  function automatic frame_t flat_frame(logic [7:0] l, logic [7:0] lm,
                                        logic [7:0] rm, logic [7:0] r);
    frame_t f;
    for (int k = 0; k < 3; k++) begin
      f.s[k] = l; f.s[3+k] = lm; f.s[6+k] = rm; f.s[9+k] = r;
    end
    return f;
  endfunction

  initial begin
    frame_t f;
    int burst;
    board.clear();
    stall_mode = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, median orderings, zero denominator, saturation
    send_frame(flat_frame(8'd0, 8'd0, 8'd0, 8'd0));
    send_frame(flat_frame(8'd255, 8'd255, 8'd255, 8'd255));
    send_frame(flat_frame(8'd100, 8'd0, 8'd0, 8'd0));
    send_frame(flat_frame(8'd0, 8'd0, 8'd0, 8'd100));
    send_frame(flat_frame(8'd0, 8'd90, 8'd0, 8'd0));
    send_frame(flat_frame(8'd50, 8'd30, 8'd70, 8'd20));
    f = flat_frame(8'd10, 8'd20, 8'd30, 8'd40);
    f.s[0] = 8'd90; f.s[1] = 8'd5; f.s[2] = 8'd40;
    f.s[3] = 8'd5; f.s[4] = 8'd90; f.s[5] = 8'd40;
    f.s[6] = 8'd40; f.s[7] = 8'd5; f.s[8] = 8'd90;
    f.s[9] = 8'd255; f.s[10] = 8'd0; f.s[11] = 8'd170;
    send_frame(f);
    f = flat_frame(8'hAA, 8'h55, 8'hFF, 8'h01);
    send_frame(f);
    pause_input();
    drain();

    write_reg(RegAdcFloor, 32'd254);
    write_reg(RegAdcCeiling, 32'd255);
    write_reg(RegModeSelect, 32'd3);
    write_reg(RegStopThreshold, 32'd0);
    send_frame(flat_frame(8'd255, 8'd253, 8'd254, 8'd0));
    send_frame(flat_frame(8'd255, 8'd255, 8'd0, 8'd255));
    pause_input();
    drain();
    // ceiling not above floor forces every level to zero
    write_reg(RegAdcFloor, 32'd200);
    write_reg(RegAdcCeiling, 32'd1);
    write_reg(RegStopThreshold, 32'd400);
    send_frame(flat_frame(8'd255, 8'd255, 8'd255, 8'd255));
    pause_input();
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      if (ph == 5) begin
        write_reg(RegAdcFloor, 32'd0);
        write_reg(RegAdcCeiling, 32'd255);
      end else begin
        write_reg(RegAdcFloor, $urandom_range(0, 120));
        write_reg(RegAdcCeiling, $urandom_range(130, 255));
      end
      write_reg(RegModeSelect, ph % 4);
      write_reg(RegStopThreshold, ph == 5 ? 32'd400 : $urandom_range(0, 511));
      for (int n = 0; n < 105; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++, n++)
          send_frame(rand_frame($urandom_range(0, 2)));
        if ($urandom_range(0, 2) != 0) begin
          pause_input();
          repeat ($urandom_range(1, 60)) @(posedge clk);
        end
      end
      pause_input();
      drain();
    end

    if (board.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
